// ===== design/prbd_pkg.sv =====
package prbd_pkg;

	// Default sizing of the plane store.
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_PLANES_DEF = 8;

	// Run-length code constants.
	localparam logic [7:0] CODE_NOP = 8'h80;
	localparam logic [7:0] LIT_MAX  = 8'h7f;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_PLANE_COUNT  = 3'd2,
		REG_COMPRESSED   = 3'd3,
		REG_REL_LIMIT    = 3'd4,
		REG_PACK_ENABLE  = 3'd5,
		REG_OUTPUT_PITCH = 3'd6
	} cfg_reg_t;

	// Run parser phase.
	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LIT  = 2'd1,
		PH_VAL  = 2'd2,
		PH_SKIP = 2'd3
	} phase_t;

	// Input sequencer state.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_EMIT
	} in_state_t;

	// Row emission sequencer state.
	typedef enum logic [2:0] {
		EM_IDLE,
		EM_START,
		EM_RADDR,
		EM_RDATA,
		EM_PACK
	} em_state_t;

	// Row geometry handed to the emitter.
	typedef struct packed {
		logic [6:0] pitch;   // plane bytes per row
		logic [3:0] rel;     // planes used per pixel
		logic       pack;    // packed output
		logic [3:0] bpo;     // output bytes per 8-pixel group
		logic [9:0] nbytes;  // output bytes per row
	} geom_t;

	// Builds the output bytes of one 8-pixel group from its plane bytes.
	// Planes not in use must be zero in pl.
	function automatic logic [63:0] group_bytes(input logic [7:0][7:0] pl,
			input logic pack, input logic [3:0] rel);
		logic [7:0][7:0] pix;
		logic [63:0]     res;
		pix = '0;
		res = '0;
		for (int j = 0; j < 8; j++) begin
			for (int p = 0; p < 8; p++) begin
				pix[j][p] = pl[p][7 - j];
			end
		end
		if (!pack) begin
			res = pix;
		end else if (rel == 4'd1) begin
			for (int m = 0; m < 8; m++) begin
				res[m] = pix[m][0];
			end
		end else if (rel == 4'd2) begin
			for (int i = 0; i < 2; i++) begin
				for (int m = 0; m < 4; m++) begin
					res[8*i + 2*m +: 2] = pix[4*i + m][1:0];
				end
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				for (int m = 0; m < 2; m++) begin
					res[8*i + 4*m +: 4] = pix[2*i + m][3:0];
				end
			end
		end
		return res;
	endfunction

endpackage

// ===== design/planar_rle_body_decoder.sv =====
// Decodes an interleaved-bitplane image body, optionally ByteRun1 coded, into
// chunky pixel rows. Body bytes enter one word per accepted transfer. A plain or
// literal byte is stored as it is taken; after the value byte of a repeat code
// the plane bytes are filled one at a time, since the plane store has a single
// write port. Once the last plane of a row is complete the row is emitted in
// 8-byte words: each 8-pixel group reads its R plane bytes (R = planes used per
// pixel) one at a time from the registered read port of the plane store and packs
// them; a group past the padded plane row is packed without a read. No body byte
// is taken during a fill or an emission. Configuration is written on its own port
// at any time and is expected to change only while no row is in flight.
module planar_rle_body_decoder import prbd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_PLANES = MAX_PLANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // body_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // pixel_word[63:0], byte_count[67:64], zero pad
	output logic        m_axis_tlast,   // row_last
	output logic        m_axis_tuser    // image_last
);

	localparam int STRIDE = ((MAX_WIDTH + 15) / 16) * 2;
	localparam int DEPTH  = MAX_PLANES * STRIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = $clog2(STRIDE);
	localparam int PLW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	// Configuration registers.
	logic [9:0]  width_q, opitch_q;
	logic [15:0] height_q;
	logic [3:0]  planes_q, limit_q;
	logic        comp_q, pack_q;

	// Parser state.
	in_state_t      st_q, st_d;
	phase_t         phase_q, phase_d;
	logic [7:0]     run_q, run_d, skip_q, skip_d, val_q;
	logic [15:0]    row_q;
	logic [PLW-1:0] plane_q;
	logic [PW-1:0]  pos_q;

	logic        acc, do_store, fill_done;
	logic [7:0]  store_val, byte_in, cnt8, len8;
	logic [9:0]  effw, opw;
	logic [10:0] w15;
	logic [3:0]  effp, lim;
	logic [15:0] effh;
	logic [7:0]  pos_inc;
	logic [6:0]  left;
	logic        plane_end, row_end, last_row, emit_busy;
	geom_t       geom;

	// Register writes.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd1;
			height_q <= 16'd1;
			planes_q <= 4'd1;
			comp_q   <= 1'b0;
			limit_q  <= 4'd8;
			pack_q   <= 1'b0;
			opitch_q <= 10'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[9:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_PLANE_COUNT:  planes_q <= cfg_data[3:0];
				REG_COMPRESSED:   comp_q   <= cfg_data[0];
				REG_REL_LIMIT:    limit_q  <= cfg_data[3:0];
				REG_PACK_ENABLE:  pack_q   <= cfg_data[0];
				REG_OUTPUT_PITCH: opitch_q <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Row geometry from the registers, with out-of-range values clamped.
	always_comb begin
		effw = (width_q == 10'd0) ? 10'd1 :
			(width_q > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_q;
		w15  = 11'(effw) + 11'd15;
		effh = (height_q == 16'd0) ? 16'd1 : height_q;
		effp = (planes_q == 4'd0) ? 4'd1 :
			(planes_q > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : planes_q;
		lim  = (limit_q == 4'd0) ? 4'd1 : limit_q;
		opw  = (opitch_q == 10'd0) ? effw :
			(opitch_q > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : opitch_q;
		geom.pitch = {w15[10:4], 1'b0} > 8'd127 ? 7'd0 : 7'({w15[10:4], 1'b0});
		geom.rel   = (lim < effp) ? lim : effp;
		geom.pack  = pack_q && (geom.rel == 4'd1 || geom.rel == 4'd2 || geom.rel == 4'd4);
		if (!geom.pack) begin
			geom.bpo    = 4'd8;
			geom.nbytes = opw;
		end else if (geom.rel == 4'd1) begin
			geom.bpo    = 4'd1;
			geom.nbytes = opw >> 3;
		end else if (geom.rel == 4'd2) begin
			geom.bpo    = 4'd2;
			geom.nbytes = opw >> 2;
		end else begin
			geom.bpo    = 4'd4;
			geom.nbytes = opw >> 1;
		end
	end

	// Plane position bookkeeping for one stored byte.
	always_comb begin
		pos_inc   = 8'(pos_q) + 8'd1;
		plane_end = pos_inc >= 8'(geom.pitch);
		row_end   = plane_end && ((4'(plane_q) + 4'd1) >= effp);
		left      = (7'(pos_q) < geom.pitch) ? geom.pitch - 7'(pos_q) : 7'd1;
		last_row  = (17'(row_q) + 17'd1) >= 17'(effh);
	end

	assign byte_in = s_axis_tdata;
	assign acc     = s_axis_tvalid && s_axis_tready;

	// Parser actions.
	always_comb begin
		do_store  = 1'b0;
		store_val = byte_in;
		phase_d   = phase_q;
		run_d     = run_q;
		skip_d    = skip_q;
		fill_done = 1'b0;
		cnt8      = 8'd0;
		len8      = 8'd0;
		if (st_q == ST_IDLE && acc) begin
			if (!comp_q) begin
				do_store = 1'b1;
			end else begin
				case (phase_q)
					PH_CODE: begin
						if (byte_in == CODE_NOP) begin
							phase_d = PH_CODE;
						end else if (byte_in <= LIT_MAX) begin
							cnt8    = byte_in + 8'd1;
							len8    = (cnt8 < 8'(left)) ? cnt8 : 8'(left);
							run_d   = len8;
							skip_d  = cnt8 - len8;
							phase_d = PH_LIT;
						end else begin
							cnt8    = 8'(9'd257 - 9'(byte_in));
							run_d   = (cnt8 < 8'(left)) ? cnt8 : 8'(left);
							phase_d = PH_VAL;
						end
					end
					PH_LIT: begin
						if (run_q != 8'd0) begin
							do_store = 1'b1;
							run_d    = run_q - 8'd1;
						end
						if (run_d == 8'd0) begin
							phase_d = (skip_q != 8'd0) ? PH_SKIP : PH_CODE;
						end
					end
					PH_VAL: begin
						phase_d = PH_VAL;
					end
					PH_SKIP: begin
						if (skip_q != 8'd0) begin
							skip_d = skip_q - 8'd1;
						end
						if (skip_d == 8'd0) begin
							phase_d = PH_CODE;
						end
					end
					default: phase_d = PH_CODE;
				endcase
			end
		end else if (st_q == ST_FILL) begin
			store_val = val_q;
			if (run_q != 8'd0) begin
				do_store = 1'b1;
				run_d    = run_q - 8'd1;
			end
			fill_done = (run_q == 8'd0) || (run_d == 8'd0) || plane_end;
			if (fill_done) begin
				run_d   = 8'd0;
				phase_d = PH_CODE;
			end
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (do_store && row_end) st_d = ST_EMIT;
				else if (acc && comp_q && phase_q == PH_VAL) st_d = ST_FILL;
			end
			ST_FILL: begin
				if (do_store && row_end) st_d = ST_EMIT;
				else if (fill_done) st_d = ST_IDLE;
			end
			ST_EMIT: if (!emit_busy) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		s_axis_tready = (st_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= PH_CODE;
			run_q   <= '0;
			skip_q  <= '0;
			row_q   <= '0;
			plane_q <= '0;
			pos_q   <= '0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			run_q   <= run_d;
			skip_q  <= skip_d;
			if (do_store) begin
				if (!plane_end) begin
					pos_q <= pos_inc[PW-1:0];
				end else begin
					pos_q <= '0;
					if (row_end) begin
						plane_q <= '0;
						row_q   <= last_row ? 16'd0 : row_q + 16'd1;
					end else begin
						plane_q <= plane_q + 1'b1;
					end
				end
			end
		end
	end

	// Repeat value held for the fill.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && acc) begin
			val_q <= byte_in;
		end
	end

	prbd_emit #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_PLANES (MAX_PLANES)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (do_store),
		.wr_addr       (AW'(AW'(plane_q) * AW'(STRIDE) + AW'(pos_q))),
		.wr_data       (store_val),
		.start         (do_store && row_end),
		.last_row      (last_row),
		.geom          (geom),
		.busy          (emit_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== design/prbd_emit.sv =====
module prbd_emit import prbd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_PLANES = MAX_PLANES_DEF,
	localparam int STRIDE = ((MAX_WIDTH + 15) / 16) * 2,
	localparam int DEPTH  = MAX_PLANES * STRIDE,
	localparam int AW     = $clog2(DEPTH),
	localparam int PW     = $clog2(STRIDE),
	localparam int PLW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          start,
	input  logic          last_row,
	input  geom_t         geom,
	output logic          busy,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [71:0]   m_axis_tdata,  // pixel_word[63:0], byte_count[67:64], zero pad
	output logic          m_axis_tlast,  // row_last
	output logic          m_axis_tuser   // image_last
);

	em_state_t st_q, st_d;

	logic [7:0]      mem [DEPTH];
	logic [7:0]      rdata_q;
	logic [PW:0]     off_q;
	logic [PLW-1:0]  lp_q;
	logic [9:0]      rem_q;
	logic [2:0]      fill_q;
	logic [63:0]     acc_q;
	logic            last_row_q;
	logic [7:0][7:0] pbuf_q;
	logic            ovld_q, orl_q, oil_q;
	logic [63:0]     oword_q;
	logic [3:0]      ocnt_q;

	logic [AW-1:0] raddr;
	logic [3:0]    cnt_g;
	logic [9:0]    rem_nx;
	logic [3:0]    fill_nx;
	logic [63:0]   gbytes, placed;
	logic          emit_word, stall, in_row, more_planes;

	// Plane store: one write port from the parser, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (st_q == EM_RADDR) begin
			rdata_q <= mem[raddr];
		end
	end

	// Group arithmetic shared by every 8-pixel group of the row.
	always_comb begin
		in_row      = 7'(off_q) < geom.pitch;
		more_planes = (4'(lp_q) + 4'd1) < geom.rel;
		raddr       = AW'(AW'(lp_q) * AW'(STRIDE) + AW'(off_q[PW-1:0]));
		cnt_g       = (rem_q < 10'(geom.bpo)) ? rem_q[3:0] : geom.bpo;
		rem_nx      = rem_q - 10'(cnt_g);
		fill_nx     = 4'(fill_q) + cnt_g;
		gbytes      = group_bytes(pbuf_q, geom.pack, geom.rel);
		for (int b = 0; b < 8; b++) begin
			if (4'(b) >= cnt_g) begin
				gbytes[8*b +: 8] = 8'h00;
			end
		end
		placed    = gbytes << {fill_q, 3'b000};
		emit_word = (fill_nx == 4'd8) || (rem_nx == 10'd0);
		stall     = emit_word && ovld_q && !m_axis_tready;
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			EM_IDLE:  if (start) st_d = EM_START;
			EM_START: begin
				if (rem_q == 10'd0) st_d = EM_IDLE;
				else if (in_row) st_d = EM_RADDR;
				else st_d = EM_PACK;
			end
			EM_RADDR: st_d = EM_RDATA;
			EM_RDATA: st_d = more_planes ? EM_RADDR : EM_PACK;
			EM_PACK:  if (!stall) st_d = EM_START;
			default:  st_d = EM_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy          = (st_q != EM_IDLE);
		m_axis_tvalid = ovld_q;
		m_axis_tdata  = {4'h0, ocnt_q, oword_q};
		m_axis_tlast  = orl_q;
		m_axis_tuser  = oil_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= EM_IDLE;
			ovld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == EM_PACK && emit_word && !stall) begin
				ovld_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// Group walk, plane buffer and word accumulator.
	always_ff @(posedge clk) begin
		case (st_q)
			EM_IDLE: begin
				if (start) begin
					rem_q      <= geom.nbytes;
					off_q      <= '0;
					fill_q     <= '0;
					acc_q      <= '0;
					last_row_q <= last_row;
				end
			end
			EM_START: begin
				pbuf_q <= '0;
				lp_q   <= '0;
			end
			EM_RDATA: begin
				pbuf_q[3'(lp_q)] <= rdata_q;
				lp_q             <= lp_q + 1'b1;
			end
			EM_PACK: begin
				if (!stall) begin
					rem_q <= rem_nx;
					off_q <= off_q + 1'b1;
					if (emit_word) begin
						oword_q <= acc_q | placed;
						ocnt_q  <= fill_nx;
						orl_q   <= (rem_nx == 10'd0);
						oil_q   <= (rem_nx == 10'd0) && last_row_q;
						acc_q   <= '0;
						fill_q  <= '0;
					end else begin
						acc_q  <= acc_q | placed;
						fill_q <= fill_nx[2:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// A new row only starts once the previous one is finished.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == EM_IDLE)
		else $error("row start while emitter busy");

	// Only the final word of a row may be short.
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !orl_q |-> ocnt_q == 4'd8)
		else $error("short word before end of row");

	// Image end only on a row end.
	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && oil_q |-> orl_q)
		else $error("image end without row end");

	// A completed word is presented on the next cycle.
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == EM_PACK && emit_word && !stall |=> ovld_q && ocnt_q != 4'd0)
		else $error("completed word not presented");

endmodule

// ===== bench/tb_planar_rle_body_decoder.sv =====
module tb_planar_rle_body_decoder;
	import prbd_pkg::*;

	localparam int STORE_W    = 64;       // plane bytes kept per plane
	localparam int SETTLE     = 1500;     // cycles a row emission may still take
	localparam int CYCLE_CAP  = 4000000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 24;

	// One output word of a chunky row.
	typedef struct {
		logic [63:0] pixels;
		logic [3:0]  count;
		logic        row_end;
		logic        image_end;
	} chunky_word_t;

	// One row of the directed stimulus table.
	typedef struct {
		bit          is_reg;
		cfg_reg_t    reg_idx;
		logic [15:0] reg_val;
		logic [7:0]  body;
		bit          typed;
		logic [63:0] typed_pixels;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // body_byte[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // pixel_word[63:0], byte_count[67:64], zero pad
	logic        m_axis_tlast;   // row_last
	logic        m_axis_tuser;   // image_last

	planar_rle_body_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	// Predicted configuration and decoder state.
	int unsigned cur_width, cur_height, cur_planes, cur_rle;
	int unsigned cur_limit, cur_pack, cur_opitch;
	logic [7:0]  plane_mem [8][STORE_W];
	int unsigned row_no, plane_no, byte_no, run_left, skip_left;
	phase_t      rle_phase;

	chunky_word_t pending_words[$];
	int unsigned  mismatches, words_checked, bytes_sent, reg_writes;
	int unsigned  sender_idle, receiver_idle;
	int unsigned  cycles;
	bit           bytes_since_cfg;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned geom_width();
		if (cur_width < 1) return 1;
		if (cur_width > 512) return 512;
		return cur_width;
	endfunction

	function automatic int unsigned geom_planes();
		if (cur_planes < 1) return 1;
		if (cur_planes > 8) return 8;
		return cur_planes;
	endfunction

	function automatic int unsigned geom_pitch();
		return ((geom_width() + 15) >> 4) << 1;
	endfunction

	// Builds the chunky row from the plane store and queues its words.
	task automatic predict_row();
		logic [7:0]  row_buf [512];
		int unsigned pitch, lim, rel, k, opitch, nbytes, npix, off, pix, cnt;
		bit          pk, last_row;
		chunky_word_t cw;
		pitch = geom_pitch();
		lim = (cur_limit == 0) ? 1 : cur_limit;
		rel = (lim < geom_planes()) ? lim : geom_planes();
		pk = (cur_pack != 0) && (rel == 1 || rel == 2 || rel == 4);
		opitch = (cur_opitch == 0) ? geom_width() : cur_opitch;
		if (opitch > 512) opitch = 512;
		k = pk ? 8 / rel : 1;
		nbytes = opitch / k;
		npix = nbytes * k;
		last_row = (row_no + 1 >= ((cur_height == 0) ? 1 : cur_height));
		foreach (row_buf[i]) row_buf[i] = '0;
		for (int unsigned x = 0; x < npix; x++) begin
			off = x >> 3;
			pix = 0;
			if (off < pitch && off < STORE_W) begin
				for (int unsigned p = 0; p < rel; p++) begin
					if (plane_mem[p][off][7 - (x & 7)]) pix |= (1 << p);
				end
			end
			if (pk) row_buf[x / k] = row_buf[x / k] | 8'(pix << ((x % k) * rel));
			else row_buf[x] = 8'(pix);
		end
		for (int unsigned i = 0; i < nbytes; i += 8) begin
			cnt = (nbytes - i < 8) ? nbytes - i : 8;
			cw.pixels = '0;
			for (int unsigned b = 0; b < cnt; b++) cw.pixels[8*b +: 8] = row_buf[i + b];
			cw.count = 4'(cnt);
			cw.row_end = (i + cnt >= nbytes);
			cw.image_end = cw.row_end && last_row;
			pending_words.push_back(cw);
		end
	endtask

	// Stores one plane byte; ended is set when it completed the plane.
	task automatic store_plane_byte(input logic [7:0] v, output bit ended);
		if (plane_no < 8 && byte_no < STORE_W) plane_mem[plane_no][byte_no] = v;
		byte_no++;
		ended = 1'b0;
		if (byte_no >= geom_pitch()) begin
			ended = 1'b1;
			byte_no = 0;
			if (plane_no + 1 >= geom_planes()) begin
				plane_no = 0;
				predict_row();
				if (row_no + 1 >= ((cur_height == 0) ? 1 : cur_height)) row_no = 0;
				else row_no++;
			end else begin
				plane_no++;
			end
		end
	endtask

	function automatic int unsigned bytes_to_plane_end();
		return (byte_no < geom_pitch()) ? geom_pitch() - byte_no : 1;
	endfunction

	// Advances the body decoder by one byte.
	task automatic decode_body_byte(input logic [7:0] b);
		bit          ended;
		int unsigned cnt, left;
		if (cur_rle == 0) begin
			store_plane_byte(b, ended);
		end else begin
			case (rle_phase)
				PH_CODE: begin
					if (b == CODE_NOP) begin
						// Nothing to do.
					end else if (b <= LIT_MAX) begin
						cnt = b + 1;
						left = bytes_to_plane_end();
						run_left = (cnt < left) ? cnt : left;
						skip_left = cnt - run_left;
						rle_phase = PH_LIT;
					end else begin
						cnt = 257 - b;
						left = bytes_to_plane_end();
						run_left = (cnt < left) ? cnt : left;
						rle_phase = PH_VAL;
					end
				end
				PH_LIT: begin
					if (run_left > 0) begin
						store_plane_byte(b, ended);
						run_left--;
					end
					if (run_left == 0) rle_phase = (skip_left > 0) ? PH_SKIP : PH_CODE;
				end
				PH_VAL: begin
					while (run_left > 0) begin
						run_left--;
						store_plane_byte(b, ended);
						if (ended) break;
					end
					run_left = 0;
					rle_phase = PH_CODE;
				end
				default: begin
					if (skip_left > 0) skip_left--;
					if (skip_left == 0) rle_phase = PH_CODE;
				end
			endcase
		end
	endtask

	// Offers one body word, with random gaps before it.
	task automatic send_body(input logic [7:0] b);
		cfg_valid <= 1'b0;
		decode_body_byte(b);
		while ($urandom_range(99) < sender_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		bytes_since_cfg = 1'b1;
	endtask

	// Writes one register once every queued word is out and the block is quiet.
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		if (bytes_since_cfg) begin
			s_axis_tvalid <= 1'b0;
			while (pending_words.size() != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			bytes_since_cfg = 1'b0;
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_IMAGE_WIDTH:  cur_width = val & 16'h3ff;
			REG_IMAGE_HEIGHT: cur_height = val;
			REG_PLANE_COUNT:  cur_planes = val & 16'hf;
			REG_COMPRESSED:   cur_rle = val & 16'h1;
			REG_REL_LIMIT:    cur_limit = val & 16'hf;
			REG_PACK_ENABLE:  cur_pack = val & 16'h1;
			REG_OUTPUT_PITCH: cur_opitch = val & 16'h3ff;
			default: ;
		endcase
	endtask

	// Picks a byte that keeps coded streams mostly well formed.
	function automatic logic [7:0] pick_body();
		int unsigned r;
		if (cur_rle == 0 || rle_phase != PH_CODE) return 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 60) return 8'($urandom_range(15));
		if (r < 85) return 8'($urandom_range(255, 240));
		if (r < 90) return CODE_NOP;
		return 8'($urandom_range(255));
	endfunction

	task automatic random_config();
		logic [15:0] w, h, pl, lim, op;
		case ($urandom_range(9))
			0: w = 16'd0;
			1: w = 16'd1023;
			2: w = 16'd512;
			default: w = 16'($urandom_range(40, 1));
		endcase
		case ($urandom_range(7))
			0: h = 16'd0;
			1: h = 16'd65535;
			default: h = 16'($urandom_range(3, 1));
		endcase
		case ($urandom_range(7))
			0: pl = 16'd0;
			1: pl = 16'd15;
			default: pl = 16'($urandom_range(8, 1));
		endcase
		if (w >= 512) pl = 16'($urandom_range(2, 1));
		lim = ($urandom_range(7) == 0) ? 16'd15 : 16'($urandom_range(8));
		case ($urandom_range(5))
			0: op = 16'd0;
			1: op = 16'd1023;
			2: op = 16'($urandom_range(7, 1));
			default: op = 16'($urandom_range(64, 1));
		endcase
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_PLANE_COUNT, pl);
		write_reg(REG_COMPRESSED, 16'($urandom_range(99) < 70));
		write_reg(REG_REL_LIMIT, lim);
		write_reg(REG_PACK_ENABLE, 16'($urandom_range(1)));
		write_reg(REG_OUTPUT_PITCH, op);
	endtask

	// Output side: random back-pressure and the word check.
	always @(posedge clk or negedge arst_n) begin
		chunky_word_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle);
			if (m_axis_tvalid && m_axis_tready) begin
				words_checked++;
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h count %0d last %b image %b",
							m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast,
							m_axis_tuser);
				end else begin
					want = pending_words.pop_front();
					if (m_axis_tdata[63:0] !== want.pixels || m_axis_tdata[67:64] !== want.count
							|| m_axis_tdata[71:68] !== 4'd0 || m_axis_tlast !== want.row_end
							|| m_axis_tuser !== want.image_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
								words_checked, want.pixels, want.count, want.row_end,
								want.image_end, m_axis_tdata[63:0], m_axis_tdata[67:64],
								m_axis_tlast, m_axis_tuser);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_planar_rle_body_decoder: errors");
			$finish;
		end
	end

	initial begin
		stim_row_t   plan[$];
		stim_row_t   r;
		int unsigned before_cnt;
		bit          want_code;
		chunky_word_t cw;

		cycles = 0;
		mismatches = 0;
		words_checked = 0;
		bytes_sent = 0;
		reg_writes = 0;
		bytes_since_cfg = 1'b0;
		sender_idle = 35;
		receiver_idle = 59;
		cur_width = 1; cur_height = 1; cur_planes = 1; cur_rle = 0;
		cur_limit = 8; cur_pack = 0; cur_opitch = 0;
		foreach (plane_mem[p, i]) plane_mem[p][i] = '0;
		row_no = 0; plane_no = 0; byte_no = 0; run_left = 0; skip_left = 0;
		rle_phase = PH_CODE;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. After reset a row is two raw bytes, and its one pixel is bit 7 of the first.
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'hff, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h00, 1, 64'd1}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h7f, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'hff, 1, 64'd0}; plan.push_back(r);
		r = '{1, REG_IMAGE_WIDTH, 16'd16, 8'h00, 0, 64'd0}; plan.push_back(r);
		r = '{1, REG_COMPRESSED, 16'd1, 8'h00, 0, 64'd0}; plan.push_back(r);
		r = '{1, REG_PACK_ENABLE, 16'd1, 8'h00, 0, 64'd0}; plan.push_back(r);
		r = '{1, REG_IMAGE_HEIGHT, 16'd2, 8'h00, 0, 64'd0}; plan.push_back(r);
		// No-op code, one-byte literal, then a repeat that ends the plane.
		r = '{0, REG_IMAGE_WIDTH, 16'd0, CODE_NOP, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h00, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'ha5, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'hff, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h3c, 0, 64'd0}; plan.push_back(r);
		// Literal run longer than the plane: the tail is read and dropped.
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h05, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h01, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h02, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h11, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h22, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h33, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h44, 0, 64'd0}; plan.push_back(r);
		// Longest repeat, cut at the plane end; image wraps to its first row.
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h81, 0, 64'd0}; plan.push_back(r);
		r = '{0, REG_IMAGE_WIDTH, 16'd0, 8'h5a, 0, 64'd0}; plan.push_back(r);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				before_cnt = pending_words.size();
				if (plan[i].typed) begin
					// Replace the prediction with the value typed in the table.
					decode_body_byte(plan[i].body);
					while (pending_words.size() > before_cnt) void'(pending_words.pop_back());
					cw = '{plan[i].typed_pixels, 4'd1, 1'b1, 1'b1};
					pending_words.push_back(cw);
					// The byte is already decoded; send it without decoding again.
					while ($urandom_range(99) < sender_idle) begin
						s_axis_tvalid <= 1'b0;
						@(posedge clk);
					end
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= plan[i].body;
					do @(posedge clk); while (!s_axis_tready);
					bytes_sent++;
					bytes_since_cfg = 1'b1;
				end else begin
					send_body(plan[i].body);
				end
			end
		end

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 2) begin
				sender_idle = 59;
				receiver_idle = 35;
			end else if (ph == 5) begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			random_config();
			for (int i = 0; i < PHASE_ITEMS; i++) send_body(pick_body());
			// Finish the current row; sometimes leave a run open across the next setting.
			want_code = (cur_rle != 0) && ($urandom_range(1) == 1);
			while (byte_no != 0 || plane_no != 0 || (want_code && rle_phase != PH_CODE)) begin
				if (cur_rle != 0 && rle_phase == PH_CODE) send_body(8'h81);
				else send_body(8'($urandom_range(255)));
			end
		end

		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d body bytes and %0d register writes over %0d settings;",
			bytes_sent, reg_writes, RAND_PHASES + 1);
		$display("%0d output words checked, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_planar_rle_body_decoder: clean");
		end else begin
			$display("tb_planar_rle_body_decoder: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/prbd_pkg.sv
design/prbd_emit.sv
design/planar_rle_body_decoder.sv
bench/tb_planar_rle_body_decoder.sv
